// ----- hdl/grid_line_of_sight_defines.svh -----
// ---------------------------------------------------------------------------
// Grid line of sight: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GLOS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid_line_of_sight: implication check failed");

// Next-cycle implication, disabled during reset.
`define GLOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid_line_of_sight: next-cycle check failed");

`endif

// ----- hdl/glos_pkg.sv -----
// ---------------------------------------------------------------------------
// Grid line of sight package
// Coordinate type, opcodes and the request structs passed to the map memory.
// ---------------------------------------------------------------------------
package glos_pkg;

  localparam int COORD_W     = 6;
  localparam int COORD_CELLS = 64;
  // Holds (1 + 2 * 63) * 63, the largest step comparison term.
  localparam int ACC_W       = 13;

  typedef logic [COORD_W-1:0] coord_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } probe_t;

  typedef struct packed {
    logic   en;
    coord_t x;
    coord_t y;
    logic   data;
  } wr_req_t;

endpackage

// ----- hdl/grid_line_of_sight.sv -----
// ---------------------------------------------------------------------------
// Grid line of sight
// Map of blocked grid cells with a supercover line-of-sight walker.
// ---------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A write beat
// updates one map cell in the cycle it is taken and leaves busy low, so the
// next command may follow at once. A query beat with equal start and end
// cells raises done with visible in the next cycle. Any other query holds
// busy while the walker probes the map, one cell entered per step and, on
// each diagonal step, the two side cells as well, read through the single
// map memory with its two read ports. done is high for one cycle with the
// visible bit and cannot be stalled. After reset busy stays high while the
// map (GRID_WIDTH by GRID_HEIGHT, both capped at 64) is swept to all free.
// ---------------------------------------------------------------------------
`include "grid_line_of_sight_defines.svh"

module grid_line_of_sight #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [glos_pkg::COORD_W-1:0] from_x,
  input  logic [glos_pkg::COORD_W-1:0] from_y,
  input  logic [glos_pkg::COORD_W-1:0] to_x,
  input  logic [glos_pkg::COORD_W-1:0] to_y,
  input  logic                         blocked,
  output logic                         done,
  output logic                         visible
);

  glos_pkg::wr_req_t wr;
  glos_pkg::probe_t  rd_a;
  glos_pkg::probe_t  rd_b;
  logic              blk_a;
  logic              blk_b;
  logic              clearing;

  glos_map #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .blk_a    (blk_a),
    .blk_b    (blk_b),
    .clearing (clearing)
  );

  glos_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .opcode   (opcode),
    .from_x   (from_x),
    .from_y   (from_y),
    .to_x     (to_x),
    .to_y     (to_y),
    .blocked  (blocked),
    .clearing (clearing),
    .blk_a    (blk_a),
    .blk_b    (blk_b),
    .busy     (busy),
    .done     (done),
    .visible  (visible),
    .wr       (wr),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  `GLOS_ASSERT_IMPLY(a_clear_busy, clk, rst, clearing, busy)
  `GLOS_ASSERT_NEXT(a_write_silent, clk, rst, start && !busy && (opcode == glos_pkg::OP_WRITE), !done)
  `GLOS_ASSERT_NEXT(a_walk_busy, clk, rst, start && !busy && (opcode == glos_pkg::OP_QUERY) && ((from_x != to_x) || (from_y != to_y)), busy && !done)

endmodule

// ----- hdl/glos_map.sv -----
// ---------------------------------------------------------------------------
// Grid line of sight map memory
// One bit per cell, one write port and two registered read ports. Cells
// outside the grid read as blocked. After reset the memory is swept to free.
// ---------------------------------------------------------------------------
module glos_map #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  glos_pkg::wr_req_t wr,
  input  glos_pkg::probe_t  rd_a,
  input  glos_pkg::probe_t  rd_b,
  output logic              blk_a,
  output logic              blk_b,
  output logic              clearing
);

  localparam int XC    = (GRID_WIDTH < glos_pkg::COORD_CELLS) ? GRID_WIDTH
                                                              : glos_pkg::COORD_CELLS;
  localparam int YC    = (GRID_HEIGHT < glos_pkg::COORD_CELLS) ? GRID_HEIGHT
                                                               : glos_pkg::COORD_CELLS;
  localparam int DEPTH = XC * YC;
  localparam int AW    = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic          wr_ok;
  logic          ok_a;
  logic          ok_b;

  function automatic logic in_grid(glos_pkg::coord_t x, glos_pkg::coord_t y);
    return (32'(x) < GRID_WIDTH) && (32'(y) < GRID_HEIGHT);
  endfunction

  function automatic logic [AW-1:0] cell_addr(glos_pkg::coord_t x, glos_pkg::coord_t y);
    if (in_grid(x, y)) begin
      return AW'(32'(y) * XC + 32'(x));
    end
    return '0;
  endfunction

  always_comb begin
    wr_ok   = in_grid(wr.x, wr.y);
    ok_a    = in_grid(rd_a.x, rd_a.y);
    ok_b    = in_grid(rd_b.x, rd_b.y);
    wr_addr = cell_addr(wr.x, wr.y);
    addr_a  = cell_addr(rd_a.x, rd_a.y);
    addr_b  = cell_addr(rd_b.x, rd_b.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr.en && wr_ok) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    blk_a <= !ok_a || mem[addr_a];
    blk_b <= !ok_b || mem[addr_b];
  end

endmodule

// ----- hdl/glos_walk.sv -----
// ---------------------------------------------------------------------------
// Grid line of sight walker
// Takes commands, issues map writes and walks a query one probe a cycle,
// checking each probe's map bits in the following cycle.
// ---------------------------------------------------------------------------
module glos_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      opcode,
  input  logic [glos_pkg::COORD_W-1:0] from_x,
  input  logic [glos_pkg::COORD_W-1:0] from_y,
  input  logic [glos_pkg::COORD_W-1:0] to_x,
  input  logic [glos_pkg::COORD_W-1:0] to_y,
  input  logic                      blocked,
  input  logic                      clearing,
  input  logic                      blk_a,
  input  logic                      blk_b,
  output logic                      busy,
  output logic                      done,
  output logic                      visible,
  output glos_pkg::wr_req_t         wr,
  output glos_pkg::probe_t          rd_a,
  output glos_pkg::probe_t          rd_b
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                         state;
  glos_pkg::coord_t               x;
  glos_pkg::coord_t               y;
  glos_pkg::coord_t               tx;
  glos_pkg::coord_t               ty;
  logic                           sx_neg;
  logic                           sy_neg;
  logic [glos_pkg::ACC_W-1:0]     lhs;
  logic [glos_pkg::ACC_W-1:0]     rhs;
  logic [glos_pkg::COORD_W:0]     nx2;
  logic [glos_pkg::COORD_W:0]     ny2;
  logic                           side;
  logic                           pend;
  logic                           use_b;
  logic                           last;

  glos_pkg::coord_t               nx_in;
  glos_pkg::coord_t               ny_in;
  glos_pkg::coord_t               x_adj;
  glos_pkg::coord_t               y_adj;
  glos_pkg::coord_t               x_new;
  glos_pkg::coord_t               y_new;
  logic                           accept;
  logic                           tie;
  logic                           step_x;
  logic                           step_y;
  logic                           side_probe;
  logic                           hit;

  always_comb begin
    busy       = (state != S_IDLE) || clearing;
    accept     = start && !busy;
    nx_in      = (from_x >= to_x) ? from_x - to_x : to_x - from_x;
    ny_in      = (from_y >= to_y) ? from_y - to_y : to_y - from_y;
    tie        = (lhs == rhs);
    step_x     = (lhs < rhs) || tie;
    step_y     = (lhs > rhs) || tie;
    x_adj      = sx_neg ? x - glos_pkg::COORD_W'(1) : x + glos_pkg::COORD_W'(1);
    y_adj      = sy_neg ? y - glos_pkg::COORD_W'(1) : y + glos_pkg::COORD_W'(1);
    x_new      = step_x ? x_adj : x;
    y_new      = step_y ? y_adj : y;
    side_probe = tie && !side;
    hit        = pend && (blk_a || (use_b && blk_b));

    wr.en   = accept && (opcode == glos_pkg::OP_WRITE);
    wr.x    = from_x;
    wr.y    = from_y;
    wr.data = blocked;

    if (side_probe) begin
      rd_a.x = x_adj;
      rd_a.y = y;
    end else begin
      rd_a.x = x_new;
      rd_a.y = y_new;
    end
    rd_b.x = x;
    rd_b.y = y_adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      visible <= 1'b0;
      pend    <= 1'b0;
      side    <= 1'b0;
      use_b   <= 1'b0;
      last    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (opcode == glos_pkg::OP_QUERY)) begin
            if ((from_x == to_x) && (from_y == to_y)) begin
              done    <= 1'b1;
              visible <= 1'b1;
            end else begin
              state  <= S_RUN;
              x      <= from_x;
              y      <= from_y;
              tx     <= to_x;
              ty     <= to_y;
              sx_neg <= !(to_x > from_x);
              sy_neg <= !(to_y > from_y);
              lhs    <= glos_pkg::ACC_W'(ny_in);
              rhs    <= glos_pkg::ACC_W'(nx_in);
              nx2    <= {nx_in, 1'b0};
              ny2    <= {ny_in, 1'b0};
              pend   <= 1'b0;
              side   <= 1'b0;
              use_b  <= 1'b0;
              last   <= 1'b0;
            end
          end
        end
        S_RUN: begin
          if (hit) begin
            state   <= S_IDLE;
            done    <= 1'b1;
            visible <= 1'b0;
            pend    <= 1'b0;
          end else if (pend && last) begin
            state   <= S_IDLE;
            done    <= 1'b1;
            visible <= 1'b1;
            pend    <= 1'b0;
          end else if (side_probe) begin
            pend  <= 1'b1;
            side  <= 1'b1;
            use_b <= 1'b1;
            last  <= 1'b0;
          end else begin
            pend  <= 1'b1;
            side  <= 1'b0;
            use_b <= 1'b0;
            last  <= (x_new == tx) && (y_new == ty);
            x     <= x_new;
            y     <= y_new;
            if (step_x) begin
              lhs <= lhs + glos_pkg::ACC_W'(ny2);
            end
            if (step_y) begin
              rhs <= rhs + glos_pkg::ACC_W'(nx2);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_grid_line_of_sight.sv -----
// ---------------------------------------------------------------------------
// Grid line of sight testbench
// Sends map writes and line-of-sight queries to the block and predicts every
// visible bit with a walker of its own that keeps its own copy of the map.
// Each done beat is checked against the oldest pending prediction. Directed
// tests cover grid corners, same-cell queries, blocked end points and blocked
// diagonal side cells. Random traffic follows in bursts, with random gaps in two of three runs.
// ---------------------------------------------------------------------------
module tb_grid_line_of_sight;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 140;

  logic             clk     = 1'b0;
  logic             rst     = 1'b1;
  logic             start   = 1'b0;
  logic             opcode  = glos_pkg::OP_WRITE;
  glos_pkg::coord_t from_x  = '0;
  glos_pkg::coord_t from_y  = '0;
  glos_pkg::coord_t to_x    = '0;
  glos_pkg::coord_t to_y    = '0;
  logic             blocked = 1'b0;
  logic             busy;
  logic             done;
  logic             visible;

  bit blocked_cells [0:GRID_W*GRID_H-1];
  bit expected_visible [$];
  int mismatch_count = 0;
  int result_count   = 0;
  int idle_count     = 0;
  int burst_left     = 0;

  grid_line_of_sight #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .opcode (opcode),
    .from_x (from_x),
    .from_y (from_y),
    .to_x   (to_x),
    .to_y   (to_y),
    .blocked(blocked),
    .done   (done),
    .visible(visible)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit cell_blocked(int x, int y);
    if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) return 1'b1;
    return blocked_cells[y*GRID_W + x];
  endfunction

  function automatic bit line_visible(int x0, int y0, int x1, int y1);
    int dx, dy, nx, ny, sx, sy, x, y, ix, iy, lhs, rhs;
    dx = x1 - x0;
    dy = y1 - y0;
    nx = (dx < 0) ? -dx : dx;
    ny = (dy < 0) ? -dy : dy;
    sx = (dx > 0) ? 1 : -1;
    sy = (dy > 0) ? 1 : -1;
    x  = x0;
    y  = y0;
    ix = 0;
    iy = 0;
    while (ix < nx || iy < ny) begin
      lhs = (1 + 2*ix) * ny;
      rhs = (1 + 2*iy) * nx;
      if (lhs < rhs) begin
        x += sx;
        ix++;
      end else if (lhs > rhs) begin
        y += sy;
        iy++;
      end else begin
        if (cell_blocked(x + sx, y) || cell_blocked(x, y + sy)) return 1'b0;
        x += sx;
        y += sy;
        ix++;
        iy++;
      end
      if (cell_blocked(x, y)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic glos_pkg::coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > GRID_W - 1) return glos_pkg::coord_t'(GRID_W - 1);
    return glos_pkg::coord_t'(v);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drives one command beat and updates the prediction once it is taken.
  task automatic send_beat(logic op, glos_pkg::coord_t fx, glos_pkg::coord_t fy,
                           glos_pkg::coord_t tx, glos_pkg::coord_t ty, logic blk);
    @(negedge clk);
    start   <= 1'b1;
    opcode  <= op;
    from_x  <= fx;
    from_y  <= fy;
    to_x    <= tx;
    to_y    <= ty;
    blocked <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == glos_pkg::OP_WRITE) begin
      if (int'(fx) < GRID_W && int'(fy) < GRID_H)
        blocked_cells[int'(fy)*GRID_W + int'(fx)] = blk;
    end else begin
      expected_visible.push_back(line_visible(fx, fy, tx, ty));
    end
  endtask

  task automatic pace_sender(bit with_gaps);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (with_gaps) begin
        if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(13, 40));
        else idle_cycles($urandom_range(1, 12));
      end
    end
    burst_left--;
  endtask

  task automatic wait_results;
    idle_cycles(1);
    while (expected_visible.size() != 0) @(posedge clk);
  endtask

  task automatic test_free_map;
    send_beat(glos_pkg::OP_QUERY, 0, 0, 63, 63, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 63, 0, 0, 63, 1'b0);
    send_beat(glos_pkg::OP_QUERY, 0, 0, 63, 0, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 0, 63, 0, 0, 1'b0);
    send_beat(glos_pkg::OP_QUERY, 63, 63, 0, 0, 1'b1);
  endtask

  task automatic test_same_cell;
    send_beat(glos_pkg::OP_WRITE, 0, 0, 63, 63, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 0, 0, 0, 0, 1'b0);
    send_beat(glos_pkg::OP_WRITE, 63, 63, 0, 0, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 63, 63, 63, 63, 1'b1);
    send_beat(glos_pkg::OP_WRITE, 0, 0, 0, 0, 1'b0);
    send_beat(glos_pkg::OP_WRITE, 63, 63, 63, 63, 1'b0);
  endtask

  task automatic test_blocked_ends;
    send_beat(glos_pkg::OP_WRITE, 5, 5, 0, 0, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 5, 5, 5, 12, 1'b0);
    send_beat(glos_pkg::OP_QUERY, 5, 0, 5, 5, 1'b1);
    send_beat(glos_pkg::OP_WRITE, 5, 5, 63, 63, 1'b0);
  endtask

  task automatic test_diagonal_sides;
    send_beat(glos_pkg::OP_WRITE, 21, 20, 0, 0, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 0, 0, 63, 63, 1'b0);
    send_beat(glos_pkg::OP_WRITE, 21, 20, 0, 0, 1'b0);
    send_beat(glos_pkg::OP_WRITE, 20, 21, 0, 0, 1'b1);
    send_beat(glos_pkg::OP_QUERY, 63, 63, 0, 0, 1'b0);
    send_beat(glos_pkg::OP_WRITE, 20, 21, 0, 0, 1'b0);
    idle_cycles(1);
  endtask

  task automatic test_random_traffic(int n, bit with_gaps);
    logic             op, blk;
    glos_pkg::coord_t fx, fy, tx, ty;
    int               d;
    repeat (n) begin
      op = ($urandom_range(0, 99) < 35) ? glos_pkg::OP_WRITE : glos_pkg::OP_QUERY;
      fx = glos_pkg::coord_t'($urandom_range(0, 63));
      fy = glos_pkg::coord_t'($urandom_range(0, 63));
      if (op == glos_pkg::OP_WRITE) blk = ($urandom_range(0, 3) == 0);
      else blk = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin
          tx = glos_pkg::coord_t'($urandom_range(0, 63));
          ty = glos_pkg::coord_t'($urandom_range(0, 63));
        end
        1: begin
          tx = clamp_coord(int'(fx) + $urandom_range(0, 12) - 6);
          ty = clamp_coord(int'(fy) + $urandom_range(0, 12) - 6);
        end
        2: begin
          d  = $urandom_range(0, 20);
          tx = clamp_coord($urandom_range(0, 1) ? int'(fx) + d : int'(fx) - d);
          ty = clamp_coord($urandom_range(0, 1) ? int'(fy) + d : int'(fy) - d);
        end
        default: begin
          tx = $urandom_range(0, 1) ? fx : glos_pkg::coord_t'($urandom_range(0, 63));
          ty = (tx == fx) ? glos_pkg::coord_t'($urandom_range(0, 63)) : fy;
        end
      endcase
      pace_sender(with_gaps);
      send_beat(op, fx, fy, tx, ty, blk);
    end
    idle_cycles(1);
  endtask

  always @(posedge clk) begin : check_results
    bit want;
    if (!rst && done) begin
      result_count++;
      if (expected_visible.size() == 0) begin
        report_mismatch($sformatf("result %0d: visible=%0b with no query pending",
                                  result_count, visible));
      end else begin
        want = expected_visible.pop_front();
        if (visible !== want)
          report_mismatch($sformatf("result %0d: visible=%0b, predicted %0b",
                                    result_count, visible, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_free_map();
    test_same_cell();
    test_blocked_ends();
    test_diagonal_sides();
    test_random_traffic(600, 1'b1);
    wait_results();
    test_random_traffic(400, 1'b0);
    test_random_traffic(800, 1'b1);
    wait_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
